// ----- src/hse_pkg.sv -----
// shared types and constants for the heap sort engine
// no dependencies; every other file imports this package
package hse_pkg;

  localparam int unsigned DATA_W           = 32;
  localparam int unsigned MAX_ELEMENTS_DEF = 64;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    data_t value;
    logic  last;
  } in_beat_t;

  typedef struct packed {
    data_t sorted_value;
    logic  final_res;
  } out_beat_t;

endpackage

// ----- src/hse_ram.sv -----
// element store: one write port, one read port with registered read data
// depends on hse_pkg for the data type
module hse_ram #(
  parameter int unsigned DEPTH = hse_pkg::MAX_ELEMENTS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  hse_pkg::data_t wdata_i,
  input  logic [AW-1:0]  raddr_i,
  output hse_pkg::data_t rdata_o
);
  import hse_pkg::*;

  data_t mem [DEPTH];
  data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/hse_sort_ctrl.sv -----
// heapsort sequencer: bottom-up heap build, then root extraction, in place
// drives the element store through one shared signed comparator; uses hse_pkg
module hse_sort_ctrl #(
  parameter int unsigned MAX_ELEMENTS = hse_pkg::MAX_ELEMENTS_DEF,
  parameter int unsigned AW           = $clog2(MAX_ELEMENTS),
  parameter int unsigned CW           = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [CW-1:0]  count_i,
  output logic           done_o,
  input  hse_pkg::data_t rdata_i,
  output logic           mem_we_o,
  output logic [AW-1:0]  mem_waddr_o,
  output hse_pkg::data_t mem_wdata_o,
  output logic [AW-1:0]  mem_raddr_o
);
  import hse_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SD_START, S_SD_HELD, S_SD_C1, S_SD_C2, S_SD_CMP, S_SD_LAST,
    S_NEXT, S_SW_R0, S_SW_RK, S_SW_W0, S_SW_WK
  } state_e;

  state_e        state_q, state_d;
  logic          extract_q, extract_d;
  logic          done_q, done_d;
  logic [AW-1:0] k_q, k_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] child_q, child_d;
  logic [AW-1:0] bottom_q, bottom_d;
  data_t         held_q, held_d;
  data_t         big_q, big_d;

  logic [AW:0]   pos_child, next_child, bottom_ext;
  data_t         cmp_a, cmp_b;
  logic          a_lt_b;

  // the one comparator, shared by child select and sift decision
  assign cmp_a  = big_q;
  assign cmp_b  = (state_q == S_SD_C2) ? rdata_i : held_q;
  assign a_lt_b = cmp_a < cmp_b;

  assign pos_child  = {pos_q, 1'b1};
  assign next_child = {child_q, 1'b1};
  assign bottom_ext = {1'b0, bottom_q};

  always_comb begin
    state_d     = state_q;
    extract_d   = extract_q;
    done_d      = 1'b0;
    k_d         = k_q;
    pos_d       = pos_q;
    child_d     = child_q;
    bottom_d    = bottom_q;
    held_d      = held_q;
    big_d       = big_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q;
    mem_wdata_o = held_q;
    mem_raddr_o = pos_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (count_i < CW'(2)) begin
            done_d = 1'b1;
          end else begin
            bottom_d  = AW'(count_i - CW'(1));
            k_d       = AW'(count_i >> 1);
            pos_d     = AW'(count_i >> 1);
            extract_d = 1'b0;
            state_d   = S_SD_START;
          end
        end
      end
      S_SD_START: begin
        if (pos_q >= bottom_q) begin
          state_d = S_NEXT;
        end else begin
          mem_raddr_o = pos_q;
          state_d     = S_SD_HELD;
        end
      end
      S_SD_HELD: begin
        held_d = rdata_i;
        if (pos_child > bottom_ext) begin
          state_d = S_NEXT;
        end else begin
          mem_raddr_o = pos_child[AW-1:0];
          child_d     = pos_child[AW-1:0];
          state_d     = S_SD_C1;
        end
      end
      S_SD_C1: begin
        big_d = rdata_i;
        if (child_q < bottom_q) begin
          mem_raddr_o = child_q + AW'(1);
          state_d     = S_SD_C2;
        end else begin
          state_d = S_SD_CMP;
        end
      end
      S_SD_C2: begin
        // right child wins when left is smaller
        if (a_lt_b) begin
          big_d   = rdata_i;
          child_d = child_q + AW'(1);
        end
        state_d = S_SD_CMP;
      end
      S_SD_CMP: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        if (a_lt_b) begin
          mem_wdata_o = held_q;
          state_d     = S_NEXT;
        end else begin
          mem_wdata_o = big_q;
          pos_d       = child_q;
          if (next_child > bottom_ext) begin
            state_d = S_SD_LAST;
          end else begin
            mem_raddr_o = next_child[AW-1:0];
            child_d     = next_child[AW-1:0];
            state_d     = S_SD_C1;
          end
        end
      end
      S_SD_LAST: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        mem_wdata_o = held_q;
        state_d     = S_NEXT;
      end
      S_NEXT: begin
        if (!extract_q) begin
          if (k_q == '0) begin
            extract_d = 1'b1;
            k_d       = bottom_q;
            state_d   = S_SW_R0;
          end else begin
            k_d     = k_q - AW'(1);
            pos_d   = k_q - AW'(1);
            state_d = S_SD_START;
          end
        end else if (k_q == AW'(1)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          k_d     = k_q - AW'(1);
          state_d = S_SW_R0;
        end
      end
      S_SW_R0: begin
        mem_raddr_o = '0;
        state_d     = S_SW_RK;
      end
      S_SW_RK: begin
        held_d      = rdata_i;
        mem_raddr_o = k_q;
        state_d     = S_SW_W0;
      end
      S_SW_W0: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = '0;
        mem_wdata_o = rdata_i;
        state_d     = S_SW_WK;
      end
      S_SW_WK: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = k_q;
        mem_wdata_o = held_q;
        pos_d       = '0;
        bottom_d    = k_q - AW'(1);
        state_d     = S_SD_START;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      extract_q <= 1'b0;
      done_q    <= 1'b0;
      k_q       <= '0;
      pos_q     <= '0;
      child_q   <= '0;
      bottom_q  <= '0;
    end else begin
      state_q   <= state_d;
      extract_q <= extract_d;
      done_q    <= done_d;
      k_q       <= k_d;
      pos_q     <= pos_d;
      child_q   <= child_d;
      bottom_q  <= bottom_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    big_q  <= big_d;
  end

  assign done_o = done_q;

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE)
    else $error("sort done while sequencer busy");
  a_child_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SD_C1 || state_q == S_SD_C2) |-> child_q <= bottom_q)
    else $error("child index beyond heap bottom");
  a_child_below_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SD_C1 |-> pos_q < child_q)
    else $error("child index not below parent");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == S_IDLE)
    else $error("start while sequencer busy");
`endif

endmodule

// ----- src/heap_sort_engine_unit.sv -----
// heap sort engine top level: load path, sequencer and store, output register
// depends on hse_pkg, hse_ram and hse_sort_ctrl
// sequence: n load beats at one per cycle while loading, then root swaps and about 3n/2 sift
//   passes of up to log2(n) levels each
// throughput: one set at a time; each result is read from the store, then registered for output
// reset: control state and element count cleared, store contents undefined
module heap_sort_engine_unit #(
  parameter int unsigned MAX_ELEMENTS = hse_pkg::MAX_ELEMENTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hse_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hse_pkg::out_beat_t out_data_o
);
  import hse_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [1:0] {
    S_LOAD, S_SORT, S_EMIT_RD, S_EMIT_WAIT
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          out_valid_q, out_valid_d;
  out_beat_t     out_q, out_d;

  logic          in_acc, out_acc;
  logic [CW-1:0] count_inc;
  logic          closes;
  logic          sort_start, sort_done;
  logic          is_final;

  // store port mux
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  data_t         ram_wdata, ram_rdata;

  // sequencer side of the store
  logic          sq_we;
  logic [AW-1:0] sq_waddr, sq_raddr;
  data_t         sq_wdata;

  assign in_stall_o  = (state_q != S_LOAD);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a set closes on the marked beat or when the store is full
  assign count_inc = count_q + CW'(1);
  assign closes    = in_data_i.last || (count_inc == CW'(MAX_ELEMENTS));
  assign is_final  = (CW'(idx_q) + CW'(1)) == count_q;

  // load writes only happen in load state, sequencer owns the store while sorting
  always_comb begin
    if (state_q == S_LOAD) begin
      ram_we    = in_acc;
      ram_waddr = count_q[AW-1:0];
      ram_wdata = in_data_i.value;
    end else begin
      ram_we    = sq_we;
      ram_waddr = sq_waddr;
      ram_wdata = sq_wdata;
    end
    ram_raddr = (state_q == S_EMIT_RD) ? idx_q : sq_raddr;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    sort_start  = 1'b0;

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          count_d = count_inc;
          if (closes) begin
            sort_start = 1'b1;
            state_d    = S_SORT;
          end
        end
      end
      S_SORT: begin
        if (sort_done) begin
          idx_d   = '0;
          state_d = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        // read issues once the output register is free or being drained
        if (!out_valid_q || out_acc) begin
          state_d = S_EMIT_WAIT;
        end
      end
      S_EMIT_WAIT: begin
        out_d.sorted_value = ram_rdata;
        out_d.final_res    = is_final;
        out_valid_d        = 1'b1;
        if (is_final) begin
          // last beat waits in the output register while the next set loads
          count_d = '0;
          state_d = S_LOAD;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = S_EMIT_RD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  hse_ram #(
    .DEPTH (MAX_ELEMENTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  hse_sort_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_sort_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (sort_start),
    .count_i     (count_inc),
    .done_o      (sort_done),
    .rdata_i     (ram_rdata),
    .mem_we_o    (sq_we),
    .mem_waddr_o (sq_waddr),
    .mem_wdata_o (sq_wdata),
    .mem_raddr_o (sq_raddr)
  );

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT_WAIT |-> !out_valid_q)
    else $error("output beat overwritten before taken");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ELEMENTS))
    else $error("element count beyond store depth");
  a_done_in_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sort_done |-> state_q == S_SORT)
    else $error("sort done outside sort phase");
  a_start_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sort_start |=> state_q == S_SORT)
    else $error("sort start without entering sort phase");
`endif

endmodule
